// ===== design/csvrb_pkg.sv =====
// Shared types and constants for the CSV record boundary partitioner.
`timescale 1ns / 1ps

package csvrb_pkg;

    localparam int FIELD_W     = 48;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [FIELD_W-1:0] TARGET_RESET = FIELD_W'(1);

    // register index lives in paddr[3] (registers sit at 8-byte stride)
    localparam logic CFG_IDX_TARGET_BYTES = 1'b0;
    localparam logic CFG_IDX_TARGET_ROWS  = 1'b1;

    typedef enum logic [1:0] {
        QS_OUTSIDE,
        QS_INQUOTE,
        QS_AFTERQ
    } quote_state_t;

    // Event handed from the byte scanner to the range builder.
    typedef struct packed {
        logic last;      // last byte of the file
        logic unclosed;  // file ended inside quotes
    } evt_ctl_t;

    localparam int EVT_CTL_W = $bits(evt_ctl_t);

endpackage

// ===== design/csv_record_boundary_partitioner_unit.sv =====
// CSV record boundary partitioner: top level with the register port.
//
// Input channel (in_valid/in_ready) takes one file byte per word, with
// last_byte marking the final byte. The scanner tracks quotes and the byte
// offset and queues only record ends and end of file. The range builder
// turns those into range words on the output channel (out_valid/out_ready):
// begin/end offset, first row, row count, final_range, or unclosed_quote.
// Throughput is one byte per cycle while in_ready is high. The byte that
// closes a range goes to the event queue, then to the output register.
// When the receiver stalls, the 4-entry event queue absorbs record ends;
// in_ready drops only when that queue is full.
// Registers: target_bytes at 0x0, target_rows at 0x8 (64-bit APB data,
// low 48 bits kept, both reset to 1). Write them only while idle.
// Reset clears the quote state, offset, range state and both channels;
// after the last byte of a file the block is ready for the next file.
`timescale 1ns / 1ps

module csv_record_boundary_partitioner_unit
    import csvrb_pkg::*;
#(
    parameter int OFFSET_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_W-1:0]    range_begin_offset,
    output logic [FIELD_W-1:0]    range_end_offset,
    output logic [FIELD_W-1:0]    range_first_row,
    output logic [FIELD_W-1:0]    range_row_count,
    output logic                  final_range,
    output logic                  unclosed_quote
);

    localparam int EVT_W = EVT_CTL_W + OFFSET_BITS;

    logic [FIELD_W-1:0]     target_bytes_reg;
    logic [FIELD_W-1:0]     target_bytes_next;
    logic [FIELD_W-1:0]     target_rows_reg;
    logic [FIELD_W-1:0]     target_rows_next;
    logic                   cfg_wr;

    logic                   in_fire;
    logic                   evt_push;
    evt_ctl_t               push_ctl;
    logic [OFFSET_BITS-1:0] push_rec_end;
    logic [EVT_W-1:0]       q_head;
    logic                   q_full;
    logic                   q_empty;
    logic                   evt_pop;
    evt_ctl_t               head_ctl;
    logic [OFFSET_BITS-1:0] head_rec_end;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        target_bytes_next = target_bytes_reg;
        target_rows_next  = target_rows_reg;
        if (cfg_wr)
        begin
            case (paddr[3])
                CFG_IDX_TARGET_BYTES: target_bytes_next = pwdata[FIELD_W-1:0];
                CFG_IDX_TARGET_ROWS:  target_rows_next  = pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            CFG_IDX_TARGET_BYTES: prdata = CFG_DATA_W'(target_bytes_reg);
            CFG_IDX_TARGET_ROWS:  prdata = CFG_DATA_W'(target_rows_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_bytes_reg <= TARGET_RESET;
            target_rows_reg  <= TARGET_RESET;
        end
        else
        begin
            target_bytes_reg <= target_bytes_next;
            target_rows_reg  <= target_rows_next;
        end
    end

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    csvrb_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .evt_push    (evt_push),
        .evt_ctl     (push_ctl),
        .evt_rec_end (push_rec_end)
    );

    csvrb_queue #(
        .WIDTH (EVT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (evt_push),
        .push_data ({push_ctl, push_rec_end}),
        .pop       (evt_pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_ctl     = q_head[EVT_W-1:OFFSET_BITS];
    assign head_rec_end = q_head[OFFSET_BITS-1:0];

    csvrb_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .evt_avail          (!q_empty),
        .evt_ctl            (head_ctl),
        .evt_rec_end        (head_rec_end),
        .evt_pop            (evt_pop),
        .target_bytes       (target_bytes_reg),
        .target_rows        (target_rows_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .range_begin_offset (range_begin_offset),
        .range_end_offset   (range_end_offset),
        .range_first_row    (range_first_row),
        .range_row_count    (range_row_count),
        .final_range        (final_range),
        .unclosed_quote     (unclosed_quote)
    );

endmodule

// ===== design/csvrb_front.sv =====
// Byte scanner: quote state machine, byte offset counter and record-end events.
`timescale 1ns / 1ps

module csvrb_front
    import csvrb_pkg::*;
#(
    parameter int OFFSET_BITS = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   evt_push,
    output evt_ctl_t               evt_ctl,
    output logic [OFFSET_BITS-1:0] evt_rec_end
);

    quote_state_t            qs_reg;
    quote_state_t            qs_next;
    quote_state_t            qs_adv;
    logic [OFFSET_BITS-1:0]  offset_reg;
    logic [OFFSET_BITS-1:0]  offset_next;
    logic [OFFSET_BITS-1:0]  rec_end;
    logic                    is_quote;
    logic                    is_newline;
    logic                    nl_end;

    assign is_quote   = (data_byte == CH_QUOTE);
    assign is_newline = (data_byte == CH_NEWLINE);
    assign rec_end    = offset_reg + OFFSET_BITS'(1);

    always_comb
    begin
        qs_adv = QS_OUTSIDE;
        nl_end = 1'b0;
        case (qs_reg)
            QS_INQUOTE:
            begin
                qs_adv = is_quote ? QS_AFTERQ : QS_INQUOTE;
            end
            QS_AFTERQ:
            begin
                // doubled quote is an escape, anything else closes the field
                if (is_quote)
                begin
                    qs_adv = QS_INQUOTE;
                end
                else
                begin
                    nl_end = is_newline;
                end
            end
            default:
            begin
                if (is_quote)
                begin
                    qs_adv = QS_INQUOTE;
                end
                else
                begin
                    nl_end = is_newline;
                end
            end
        endcase
    end

    always_comb
    begin
        qs_next     = qs_reg;
        offset_next = offset_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                qs_next     = QS_OUTSIDE;
                offset_next = '0;
            end
            else
            begin
                qs_next     = qs_adv;
                offset_next = rec_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qs_reg     <= QS_OUTSIDE;
            offset_reg <= '0;
        end
        else
        begin
            qs_reg     <= qs_next;
            offset_reg <= offset_next;
        end
    end

    assign evt_push         = in_fire && (last_byte || nl_end);
    assign evt_ctl.last     = last_byte;
    assign evt_ctl.unclosed = last_byte && (qs_adv == QS_INQUOTE);
    assign evt_rec_end      = rec_end;

endmodule

// ===== design/csvrb_queue.sv =====
// Small event queue between the byte scanner and the range builder.
`timescale 1ns / 1ps

module csvrb_queue
    import csvrb_pkg::*;
#(
    parameter int WIDTH = 50
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/csvrb_back.sv =====
// Range builder: record counting, cut decision and the output word register.
`timescale 1ns / 1ps

module csvrb_back
    import csvrb_pkg::*;
#(
    parameter int OFFSET_BITS = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_avail,
    input  evt_ctl_t               evt_ctl,
    input  logic [OFFSET_BITS-1:0] evt_rec_end,
    output logic                   evt_pop,
    input  logic [FIELD_W-1:0]     target_bytes,
    input  logic [FIELD_W-1:0]     target_rows,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FIELD_W-1:0]     range_begin_offset,
    output logic [FIELD_W-1:0]     range_end_offset,
    output logic [FIELD_W-1:0]     range_first_row,
    output logic [FIELD_W-1:0]     range_row_count,
    output logic                   final_range,
    output logic                   unclosed_quote
);

    localparam int CMP_W = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;

    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_next;
    logic [OFFSET_BITS-1:0] first_reg;
    logic [OFFSET_BITS-1:0] first_next;
    logic [OFFSET_BITS-1:0] records_reg;
    logic [OFFSET_BITS-1:0] records_next;
    logic [OFFSET_BITS-1:0] rows;
    logic [OFFSET_BITS-1:0] len;
    logic                   cut;
    logic                   emit;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FIELD_W-1:0]     begin_reg;
    logic [FIELD_W-1:0]     end_reg;
    logic [FIELD_W-1:0]     first_row_reg;
    logic [FIELD_W-1:0]     row_count_reg;
    logic                   final_reg;
    logic                   unclosed_reg;

    assign evt_pop = evt_avail && (!out_valid_reg || out_ready);

    assign rows = records_reg + OFFSET_BITS'(1);
    assign len  = evt_rec_end - start_reg;
    assign cut  = (CMP_W'(len) >= CMP_W'(target_bytes))
               || (CMP_W'(rows) >= CMP_W'(target_rows));
    assign emit = evt_ctl.last || cut;

    always_comb
    begin
        start_next     = start_reg;
        first_next     = first_reg;
        records_next   = records_reg;
        out_valid_next = out_valid_reg;
        if (evt_pop)
        begin
            out_valid_next = emit;
            if (evt_ctl.last)
            begin
                start_next   = '0;
                first_next   = '0;
                records_next = '0;
            end
            else if (cut)
            begin
                start_next   = evt_rec_end;
                first_next   = first_reg + rows;
                records_next = '0;
            end
            else
            begin
                records_next = rows;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            first_reg     <= '0;
            records_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            first_reg     <= first_next;
            records_reg   <= records_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload word, loaded whenever a range leaves the builder
    always_ff @(posedge clk)
    begin
        if (evt_pop && emit)
        begin
            if (evt_ctl.unclosed)
            begin
                begin_reg     <= '0;
                end_reg       <= '0;
                first_row_reg <= '0;
                row_count_reg <= '0;
                final_reg     <= 1'b0;
                unclosed_reg  <= 1'b1;
            end
            else
            begin
                begin_reg     <= FIELD_W'(start_reg);
                end_reg       <= FIELD_W'(evt_rec_end);
                first_row_reg <= FIELD_W'(first_reg);
                row_count_reg <= FIELD_W'(rows);
                final_reg     <= evt_ctl.last;
                unclosed_reg  <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign range_begin_offset = begin_reg;
    assign range_end_offset   = end_reg;
    assign range_first_row    = first_row_reg;
    assign range_row_count    = row_count_reg;
    assign final_range        = final_reg;
    assign unclosed_quote     = unclosed_reg;

endmodule

// ===== design/csvrb_checker.sv =====
// Port-level checks for the CSV record boundary partitioner, bound to the top.
`timescale 1ns / 1ps

module csvrb_checker
    import csvrb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  pready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [FIELD_W-1:0]    range_begin_offset,
    input logic [FIELD_W-1:0]    range_end_offset,
    input logic [FIELD_W-1:0]    range_first_row,
    input logic [FIELD_W-1:0]    range_row_count,
    input logic                  final_range,
    input logic                  unclosed_quote
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(range_begin_offset) && $stable(range_end_offset)
            && $stable(range_first_row) && $stable(range_row_count)
            && $stable(final_range) && $stable(unclosed_quote))
        else $error("output word changed while stalled");

    // an unclosed-quote word carries no range
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unclosed_quote |-> !final_range
            && (range_begin_offset == '0) && (range_end_offset == '0)
            && (range_first_row == '0) && (range_row_count == '0))
        else $error("unclosed-quote word has range fields");

    // nothing can come out in the first cycle after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output word right after reset");

    // the register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind csv_record_boundary_partitioner_unit csvrb_checker u_csvrb_checker (.*);
